[rtl/sdp_pkg.sv]
// Shared types and constants for the sparse dot product block.
// Holds the beat structs, operation codes and sequencer states; no dependencies.
package sdp_pkg;

  localparam int unsigned MaxNonzerosDef = 256;
  localparam int unsigned IndexBitsDef   = 16;
  localparam int unsigned FieldIdxW      = 16;
  localparam int unsigned ValueW         = 32;
  localparam int unsigned AccW           = 64;
  localparam int unsigned MatchW         = 9;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_CMP   = 4'b0100,
    S_ACC   = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [FieldIdxW-1:0]      feature_index;
    logic signed [ValueW-1:0]  feature_value;
  } in_t;

  typedef struct packed {
    logic signed [AccW-1:0]    dot_value;
    logic [MatchW-1:0]         match_count;
    logic                      list_overflowed;
    logic                      saturated;
  } out_t;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [AccW-1:0] BinaryTerm = AccW'(64'h0000_0001_0000_0000);

endpackage

[rtl/sdp_list_mem.sv]
// Single-port-write, single-port-read list storage with registered read data.
// Used for list A and list B of the sparse dot product; no package dependency.
module sdp_list_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 48,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sparse_dot_product.sv]
// Sparse dot product top level: a load beat appends to list A or B, and a compute
// beat merges the lists step by step (memory read, compare and multiply, and on a
// match a saturating add), finishing once either list is exhausted.
// The result strobe rises the cycle after the merge ends; busy is high throughout.
// The strobe cannot be stalled. Reset clears the counts, flags and binary mode;
// list contents are undefined until loaded. Depends on sdp_pkg and sdp_list_mem.
module sparse_dot_product #(
  parameter int unsigned MaxNonzeros = sdp_pkg::MaxNonzerosDef,
  parameter int unsigned IndexBits   = sdp_pkg::IndexBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sdp_pkg::in_t   item_i,
  output logic           result_valid_o,
  output sdp_pkg::out_t  result_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i
);

  localparam int unsigned AddrW = (MaxNonzeros > 1) ? $clog2(MaxNonzeros) : 1;
  localparam int unsigned CntW  = $clog2(MaxNonzeros + 1);
  localparam int unsigned IdxW  = (IndexBits < sdp_pkg::FieldIdxW) ? IndexBits
                                                                   : sdp_pkg::FieldIdxW;
  localparam int unsigned EntW  = IdxW + sdp_pkg::ValueW;
  localparam logic [CntW-1:0] CntMax = CntW'(MaxNonzeros);

  sdp_pkg::state_e state_q, state_d;
  logic [CntW-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [CntW-1:0] pa_q, pa_d, pb_q, pb_d, match_q, match_d;
  logic            drop_q, drop_d, clip_q, clip_d, bin_q;
  logic signed [sdp_pkg::AccW-1:0] acc_q, acc_d, prod_q, prod_d;
  logic            res_valid_q, res_valid_d;
  sdp_pkg::out_t   res_q, res_d;

  logic            accept, load_a, load_b;
  logic [EntW-1:0] wentry, a_rd, b_rd;
  logic [IdxW-1:0] ia, ib;
  logic signed [sdp_pkg::ValueW-1:0] va, vb;
  logic signed [sdp_pkg::AccW-1:0]   mul_full;
  logic signed [sdp_pkg::AccW:0]     sum;

  assign busy   = (state_q != sdp_pkg::S_IDLE);
  assign accept = start && !busy;
  assign load_a = accept && (item_i.operation == sdp_pkg::OP_LOAD_A) && (a_cnt_q < CntMax);
  assign load_b = accept && (item_i.operation == sdp_pkg::OP_LOAD_B) && (b_cnt_q < CntMax);
  assign wentry = {item_i.feature_index[IdxW-1:0], item_i.feature_value};

  sdp_list_mem #(.Depth(MaxNonzeros), .Width(EntW)) u_list_a (
    .clk_i   (clk_i),
    .we_i    (load_a),
    .waddr_i (AddrW'(a_cnt_q)),
    .wdata_i (wentry),
    .raddr_i (AddrW'(pa_q)),
    .rdata_o (a_rd)
  );

  sdp_list_mem #(.Depth(MaxNonzeros), .Width(EntW)) u_list_b (
    .clk_i   (clk_i),
    .we_i    (load_b),
    .waddr_i (AddrW'(b_cnt_q)),
    .wdata_i (wentry),
    .raddr_i (AddrW'(pb_q)),
    .rdata_o (b_rd)
  );

  assign ia       = a_rd[EntW-1:sdp_pkg::ValueW];
  assign ib       = b_rd[EntW-1:sdp_pkg::ValueW];
  assign va       = $signed(a_rd[sdp_pkg::ValueW-1:0]);
  assign vb       = $signed(b_rd[sdp_pkg::ValueW-1:0]);
  assign mul_full = va * vb;
  assign sum      = {acc_q[sdp_pkg::AccW-1], acc_q} + {prod_q[sdp_pkg::AccW-1], prod_q};

  always_comb begin
    state_d     = state_q;
    a_cnt_d     = a_cnt_q;
    b_cnt_d     = b_cnt_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    match_d     = match_q;
    drop_d      = drop_q;
    clip_d      = clip_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      sdp_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item_i.operation)
            sdp_pkg::OP_LOAD_A: begin
              if (load_a) begin
                a_cnt_d = a_cnt_q + CntW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            sdp_pkg::OP_LOAD_B: begin
              if (load_b) begin
                b_cnt_d = b_cnt_q + CntW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            sdp_pkg::OP_COMPUTE: begin
              pa_d    = '0;
              pb_d    = '0;
              match_d = '0;
              clip_d  = 1'b0;
              acc_d   = '0;
              state_d = sdp_pkg::S_FETCH;
            end
            default: begin
            end
          endcase
        end
      end
      sdp_pkg::S_FETCH: begin
        if ((pa_q < a_cnt_q) && (pb_q < b_cnt_q)) begin
          state_d = sdp_pkg::S_CMP;
        end else begin
          res_valid_d           = 1'b1;
          res_d.dot_value       = acc_q;
          res_d.match_count     = sdp_pkg::MatchW'(match_q);
          res_d.list_overflowed = drop_q;
          res_d.saturated       = clip_q;
          a_cnt_d               = '0;
          b_cnt_d               = '0;
          drop_d                = 1'b0;
          state_d               = sdp_pkg::S_IDLE;
        end
      end
      sdp_pkg::S_CMP: begin
        priority if (ia == ib) begin
          prod_d  = bin_q ? sdp_pkg::BinaryTerm : mul_full;
          pa_d    = pa_q + CntW'(1);
          pb_d    = pb_q + CntW'(1);
          match_d = match_q + CntW'(1);
          state_d = sdp_pkg::S_ACC;
        end else if (ia > ib) begin
          pb_d    = pb_q + CntW'(1);
          state_d = sdp_pkg::S_FETCH;
        end else begin
          pa_d    = pa_q + CntW'(1);
          state_d = sdp_pkg::S_FETCH;
        end
      end
      sdp_pkg::S_ACC: begin
        if (sum[sdp_pkg::AccW] != sum[sdp_pkg::AccW-1]) begin
          acc_d  = prod_q[sdp_pkg::AccW-1] ? sdp_pkg::AccMin : sdp_pkg::AccMax;
          clip_d = 1'b1;
        end else begin
          acc_d = sum[sdp_pkg::AccW-1:0];
        end
        state_d = sdp_pkg::S_FETCH;
      end
      default: begin
        state_d = sdp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdp_pkg::S_IDLE;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      match_q     <= '0;
      drop_q      <= 1'b0;
      clip_q      <= 1'b0;
      bin_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_cnt_q     <= a_cnt_d;
      b_cnt_q     <= b_cnt_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      match_q     <= match_d;
      drop_q      <= drop_d;
      clip_q      <= clip_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        bin_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
